[src/gsdc_pkg.sv]
// ----------------------------------------------------------------------------
// gsdc_pkg
// Types, constants and helpers shared by the grid segment digit classifier.
// ----------------------------------------------------------------------------
package gsdc_pkg;

  localparam int DIM_W         = 9;
  localparam int PIX_W         = 8;
  localparam int DIGIT_W       = 4;
  localparam int CNT_W         = 16;
  localparam int NUM_CELLS     = 15;
  localparam int CELL_W        = 4;
  localparam int MUL_W         = DIM_W + 1;
  localparam int T_W           = 2 * DIM_W;
  localparam int FIFO_DEPTH    = 4;
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam logic [DIM_W-1:0]  RESET_DIM = DIM_W'(32);
  localparam logic [CELL_W-1:0] CELL_NONE = CELL_W'(15);
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

  // Exact reciprocals for 9-bit operands.
  localparam logic [15:0] DIV3_MUL   = 16'd43691;
  localparam int          DIV3_SHIFT = 17;
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  // Segment order: top, mid, bottom, left-top, left-bottom, right-top, right-bottom.
  localparam logic [6:0] SEG_D0 = 7'b1011111;
  localparam logic [6:0] SEG_D1 = 7'b0000011;
  localparam logic [6:0] SEG_D2 = 7'b1110110;
  localparam logic [6:0] SEG_D3 = 7'b1110011;
  localparam logic [6:0] SEG_D4 = 7'b0101111;
  localparam logic [6:0] SEG_D5 = 7'b1111001;
  localparam logic [6:0] SEG_D6 = 7'b1111101;
  localparam logic [6:0] SEG_D7 = 7'b1000011;
  localparam logic [6:0] SEG_D8 = 7'b1111111;
  localparam logic [6:0] SEG_D9 = 7'b1111011;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               recognized;
  } out_item_t;

  typedef struct packed {
    cfg_idx_t         index;
    logic [DIM_W-1:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [MUL_W-1:0] gw1;
    logic [MUL_W-1:0] gw2;
    logic [MUL_W-1:0] gw3;
    logic [MUL_W-1:0] gh1;
    logic [MUL_W-1:0] gh2;
    logic [MUL_W-1:0] gh3;
    logic [MUL_W-1:0] gh4;
    logic [MUL_W-1:0] gh5;
    logic [T_W-1:0]   t;
  } geom_t;

  typedef struct packed {
    logic              clear;
    logic              black;
    logic              upd;
    logic [CELL_W-1:0] cell_idx;
    logic [DIM_W-1:0]  x;
    logic [DIM_W-1:0]  y;
    logic              last;
  } op_t;

  typedef struct packed {
    logic [DIM_W-1:0] min_x;
    logic [DIM_W-1:0] max_x;
    logic [DIM_W-1:0] min_y;
    logic [DIM_W-1:0] max_y;
  } box_t;

  typedef logic [NUM_CELLS-1:0][CNT_W-1:0] counts_t;

  typedef struct packed {
    counts_t        counts;
    box_t           box;
    logic [T_W-1:0] t;
  } snap_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input int unsigned maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = DIM_W'(maxv);
    end
    return r;
  endfunction

endpackage

[src/gsdc_stream_if.sv]
// ----------------------------------------------------------------------------
// gsdc_stream_if
// Valid/ready channel carrying one payload of a chosen type per transaction.
// ----------------------------------------------------------------------------
interface gsdc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/grid_segment_digit_classifier.sv]
// ----------------------------------------------------------------------------
// grid_segment_digit_classifier
// Counts black pixels of a raster frame in a 5x3 grid, tracks the bounding
// box and classifies the frame as a digit after its last pixel.
//
//   Channel  Dir  Payload                         Transaction
//   in_ch    in   pixel_value, start_of_frame     one pixel
//   out_ch   out  digit, recognized               one result per frame
//   cfg_ch   in   index, value                    one register write
//
// One pixel is taken per cycle while the queue has room and no geometry
// recompute is pending; the front path decodes position and cell, and the
// counter update runs behind it across the queue. With out_ch ready, the
// last pixel of a frame passes the queue entry and the snapshot, segment and
// output registers before out_ch.valid rises. After reset and after each
// register write, in_ch.ready is low while the frame geometry is recomputed.
// A stalled out_ch fills the result pipeline and then the 4-entry queue
// before in_ch.ready drops.
// ----------------------------------------------------------------------------
module grid_segment_digit_classifier
  import gsdc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  gsdc_stream_if.sink   in_ch,
  gsdc_stream_if.source out_ch,
  gsdc_stream_if.sink   cfg_ch
);

  logic  push, full, pop, empty, snap_valid, snap_ready;
  op_t   push_op, pop_op;
  geom_t geom;
  snap_t snap;

  gsdc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .fifo_full (full),
    .push      (push),
    .push_op   (push_op),
    .geom      (geom)
  );

  gsdc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .pop_op  (pop_op),
    .empty   (empty)
  );

  gsdc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .op         (pop_op),
    .geom       (geom),
    .pop        (pop),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  gsdc_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .out_ch     (out_ch)
  );

endmodule

[src/gsdc_front.sv]
// ----------------------------------------------------------------------------
// gsdc_front
// Configuration registers, frame geometry, raster position and cell lookup.
// ----------------------------------------------------------------------------
module gsdc_front
  import gsdc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  gsdc_stream_if.sink   in_ch,
  gsdc_stream_if.sink   cfg_ch,
  input  logic          fifo_full,
  output logic          push,
  output op_t           push_op,
  output geom_t         geom
);

  logic [DIM_W-1:0] width_r, height_r;
  logic [1:0]       hold_r;
  logic [DIM_W-1:0] w_a_r, h_a_r, gw_a_r, gh_a_r;
  geom_t            geom_r;
  logic [DIM_W-1:0] col_r, row_r;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [24:0]      w_prod, h_prod;
  logic             accept;
  logic [DIM_W-1:0] x0, y0;
  logic [MUL_W-1:0] x0e, y0e, col_inc, row_inc;
  logic             active, wrap, last;
  logic [1:0]       cidx;
  logic [2:0]       ridx;
  logic             cok, rok;
  logic [DIM_W-1:0] col_nxt, row_nxt;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !fifo_full && (hold_r == '0);
  assign accept       = in_ch.valid && in_ch.ready;
  assign geom         = geom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_DIM;
      height_r <= RESET_DIM;
      hold_r   <= 2'd3;
    end else if (cfg_ch.valid) begin
      hold_r <= 2'd3;
      case (cfg_ch.data.index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_ch.data.value;
        REG_IMAGE_HEIGHT: height_r <= cfg_ch.data.value;
        default: ;
      endcase
    end else if (hold_r != '0) begin
      hold_r <= hold_r - 2'd1;
    end
  end

  assign w_eff  = eff_dim(width_r, MAX_WIDTH);
  assign h_eff  = eff_dim(height_r, MAX_HEIGHT);
  assign w_prod = 25'(w_eff) * 25'(DIV3_MUL);
  assign h_prod = 25'(h_eff) * 25'(DIV5_MUL);

  always_ff @(posedge clk) begin
    w_a_r  <= w_eff;
    h_a_r  <= h_eff;
    gw_a_r <= DIM_W'(w_prod >> DIV3_SHIFT);
    gh_a_r <= DIM_W'(h_prod >> DIV5_SHIFT);

    geom_r.w   <= w_a_r;
    geom_r.h   <= h_a_r;
    geom_r.gw1 <= MUL_W'(gw_a_r);
    geom_r.gw2 <= MUL_W'(gw_a_r) << 1;
    geom_r.gw3 <= (MUL_W'(gw_a_r) << 1) + MUL_W'(gw_a_r);
    geom_r.gh1 <= MUL_W'(gh_a_r);
    geom_r.gh2 <= MUL_W'(gh_a_r) << 1;
    geom_r.gh3 <= (MUL_W'(gh_a_r) << 1) + MUL_W'(gh_a_r);
    geom_r.gh4 <= MUL_W'(gh_a_r) << 2;
    geom_r.gh5 <= (MUL_W'(gh_a_r) << 2) + MUL_W'(gh_a_r);
    geom_r.t   <= T_W'(gh_a_r) * T_W'(gw_a_r);
  end

  always_comb begin
    x0      = in_ch.data.start_of_frame ? '0 : col_r;
    y0      = in_ch.data.start_of_frame ? '0 : row_r;
    x0e     = MUL_W'(x0);
    y0e     = MUL_W'(y0);
    active  = (y0 < geom_r.h);
    col_inc = x0e + MUL_W'(1);
    row_inc = y0e + MUL_W'(1);
    wrap    = (col_inc >= MUL_W'(geom_r.w));
    col_nxt = wrap ? '0 : DIM_W'(col_inc);
    row_nxt = wrap ? DIM_W'(row_inc) : y0;
    last    = wrap && (row_inc >= MUL_W'(geom_r.h));

    cok  = 1'b1;
    cidx = 2'd0;
    if (x0e < geom_r.gw1) begin
      cidx = 2'd0;
    end else if (x0e < geom_r.gw2) begin
      cidx = 2'd1;
    end else if (x0e < geom_r.gw3) begin
      cidx = 2'd2;
    end else begin
      cok = 1'b0;
    end

    rok  = 1'b1;
    ridx = 3'd0;
    if (y0e < geom_r.gh1) begin
      ridx = 3'd0;
    end else if (y0e < geom_r.gh2) begin
      ridx = 3'd1;
    end else if (y0e < geom_r.gh3) begin
      ridx = 3'd2;
    end else if (y0e < geom_r.gh4) begin
      ridx = 3'd3;
    end else if (y0e < geom_r.gh5) begin
      ridx = 3'd4;
    end else begin
      rok = 1'b0;
    end

    push             = accept && active;
    push_op.clear    = in_ch.data.start_of_frame;
    push_op.black    = (in_ch.data.pixel_value == '0);
    push_op.upd      = push_op.black && cok && rok;
    push_op.cell_idx = (cok && rok)
                     ? (CELL_W'({ridx, 1'b0}) + CELL_W'(ridx) + CELL_W'(cidx))
                     : CELL_NONE;
    push_op.x        = x0;
    push_op.y        = y0;
    push_op.last     = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

[src/gsdc_fifo.sv]
// ----------------------------------------------------------------------------
// gsdc_fifo
// Short register queue of pixel operations between the front and back parts.
// ----------------------------------------------------------------------------
module gsdc_fifo
  import gsdc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output op_t  pop_op,
  output logic empty
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W_Q = $clog2(FIFO_DEPTH + 1);

  op_t                mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W_Q-1:0] count_r;

  assign full   = (count_r == CNT_W_Q'(FIFO_DEPTH));
  assign empty  = (count_r == '0);
  assign pop_op = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W_Q'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W_Q'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W_Q'(FIFO_DEPTH))
    else $error("queue fill count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !(push && !pop))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("pop from an empty queue");

endmodule

[src/gsdc_back.sv]
// ----------------------------------------------------------------------------
// gsdc_back
// Applies queued pixel operations to the cell counters and bounding box.
// ----------------------------------------------------------------------------
module gsdc_back
  import gsdc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  empty,
  input  op_t   op,
  input  geom_t geom,
  output logic  pop,
  output logic  snap_valid,
  output snap_t snap,
  input  logic  snap_ready
);

  counts_t counts_r, counts_base, counts_nxt;
  box_t    box_r, box_base, box_nxt;

  assign pop        = !empty && (!op.last || snap_ready);
  assign snap_valid = pop && op.last;

  always_comb begin
    if (op.clear) begin
      counts_base   = '0;
      box_base.min_x = geom.w;
      box_base.max_x = '0;
      box_base.min_y = geom.h;
      box_base.max_y = '0;
    end else begin
      counts_base = counts_r;
      box_base    = box_r;
    end

    counts_nxt = counts_base;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (op.upd && (op.cell_idx == CELL_W'(i)) && (counts_base[i] != CNT_MAX)) begin
        counts_nxt[i] = counts_base[i] + CNT_W'(1);
      end
    end

    box_nxt = box_base;
    if (op.black) begin
      if (op.x < box_base.min_x) box_nxt.min_x = op.x;
      if (op.x > box_base.max_x) box_nxt.max_x = op.x;
      if (op.y < box_base.min_y) box_nxt.min_y = op.y;
      if (op.y > box_base.max_y) box_nxt.max_y = op.y;
    end

    snap.counts = counts_nxt;
    snap.box    = box_nxt;
    snap.t      = geom.t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counts_r    <= '0;
      box_r.min_x <= RESET_DIM;
      box_r.max_x <= '0;
      box_r.min_y <= RESET_DIM;
      box_r.max_y <= '0;
    end else if (pop) begin
      counts_r <= counts_nxt;
      box_r    <= box_nxt;
    end
  end

endmodule

[src/gsdc_classify.sv]
// ----------------------------------------------------------------------------
// gsdc_classify
// Segment flags, pattern match and aspect-ratio fallback for a finished frame.
// ----------------------------------------------------------------------------
module gsdc_classify
  import gsdc_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           snap_valid,
  input  snap_t          snap,
  output logic           snap_ready,
  gsdc_stream_if.source  out_ch
);

  localparam int SUM_W = CNT_W + 2;
  localparam int CMP_W = T_W + 2;
  localparam int ASP_W = DIM_W + 4;

  logic               s1_valid_r, s2_valid_r, out_valid_r;
  snap_t              s1_r;
  logic [6:0]         seg_r;
  logic               degen_r;
  logic [DIM_W-1:0]   dx_r, dy_r;
  out_item_t          out_r;

  logic               out_adv, s2_adv;
  logic [6:0]         seg;
  out_item_t          res;
  logic [ASP_W-1:0]   dx, dy, dx5, dx10, dy3, dy4, dy6, dy7, dy13;

  function automatic logic seg_on(input logic [SUM_W-1:0] sum,
                                  input logic [1:0] n,
                                  input logic [T_W-1:0] t);
    logic [CMP_W-1:0] lhs, rhs;
    lhs = CMP_W'(sum) << 2;
    rhs = CMP_W'(t) * CMP_W'(n);
    return lhs > rhs;
  endfunction

  assign out_adv      = !out_valid_r || out_ch.ready;
  assign s2_adv       = !s2_valid_r || out_adv;
  assign snap_ready   = !s1_valid_r || s2_adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    seg[6] = seg_on(SUM_W'(s1_r.counts[0]) + SUM_W'(s1_r.counts[1])
                    + SUM_W'(s1_r.counts[2]), 2'd3, s1_r.t);
    seg[5] = seg_on(SUM_W'(s1_r.counts[6]) + SUM_W'(s1_r.counts[7])
                    + SUM_W'(s1_r.counts[8]), 2'd3, s1_r.t);
    seg[4] = seg_on(SUM_W'(s1_r.counts[12]) + SUM_W'(s1_r.counts[13])
                    + SUM_W'(s1_r.counts[14]), 2'd3, s1_r.t);
    seg[3] = seg_on(SUM_W'(s1_r.counts[0]) + SUM_W'(s1_r.counts[3]), 2'd2, s1_r.t);
    seg[2] = seg_on(SUM_W'(s1_r.counts[9]) + SUM_W'(s1_r.counts[12]), 2'd2, s1_r.t);
    seg[1] = seg_on(SUM_W'(s1_r.counts[2]) + SUM_W'(s1_r.counts[5]), 2'd2, s1_r.t);
    seg[0] = seg_on(SUM_W'(s1_r.counts[11]) + SUM_W'(s1_r.counts[14]), 2'd2, s1_r.t);
  end

  always_comb begin
    dx   = ASP_W'(dx_r);
    dy   = ASP_W'(dy_r);
    dx5  = (dx << 2) + dx;
    dx10 = (dx << 3) + (dx << 1);
    dy3  = (dy << 1) + dy;
    dy4  = dy << 2;
    dy6  = (dy << 2) + (dy << 1);
    dy7  = (dy << 3) - dy;
    dy13 = (dy << 3) + (dy << 2) + dy;

    res.recognized = 1'b1;
    res.digit      = DIGIT_W'(0);
    case (seg_r)
      SEG_D0: res.digit = DIGIT_W'(0);
      SEG_D1: res.digit = DIGIT_W'(1);
      SEG_D2: res.digit = DIGIT_W'(2);
      SEG_D3: res.digit = DIGIT_W'(3);
      SEG_D4: res.digit = DIGIT_W'(4);
      SEG_D5: res.digit = DIGIT_W'(5);
      SEG_D6: res.digit = DIGIT_W'(6);
      SEG_D7: res.digit = DIGIT_W'(7);
      SEG_D8: res.digit = DIGIT_W'(8);
      SEG_D9: res.digit = DIGIT_W'(9);
      default: begin
        if (degen_r) begin
          res.recognized = 1'b0;
          res.digit      = DIGIT_W'(0);
        end else if ((dx5 > dy4) && (dx5 < dy6)) begin
          res.digit = DIGIT_W'(0);
        end else if (dx5 < dy3) begin
          res.digit = DIGIT_W'(1);
        end else if ((dx10 > dy7) && (dx10 < dy13)) begin
          res.digit = seg_r[5] ? DIGIT_W'(8) : DIGIT_W'(0);
        end else begin
          res.digit = DIGIT_W'(8);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (snap_ready) begin
      s1_r <= snap;
    end
    if (s2_adv) begin
      seg_r   <= seg;
      degen_r <= (s1_r.box.max_x <= s1_r.box.min_x) || (s1_r.box.max_y <= s1_r.box.min_y);
      dx_r    <= s1_r.box.max_x - s1_r.box.min_x;
      dy_r    <= s1_r.box.max_y - s1_r.box.min_y;
    end
    if (out_adv) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (snap_ready) s1_valid_r  <= snap_valid;
      if (s2_adv)     s2_valid_r  <= s1_valid_r;
      if (out_adv)    out_valid_r <= s2_valid_r;
    end
  end

  a_unrec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.recognized || (out_r.digit == '0)))
    else $error("unrecognized result with nonzero digit");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.digit <= DIGIT_W'(9)))
    else $error("digit out of range");

endmodule

[tb/grid_segment_digit_classifier_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_segment_digit_classifier_test
// Streams raster frames of many sizes through the digit classifier with
// random gaps on the pixel side and random stalls on the result side. A
// predictor keeps its own grid counts, bounding box and frame position, and
// every result transaction is checked against it field by field.
// ----------------------------------------------------------------------------
module grid_segment_digit_classifier_test;
  import gsdc_pkg::*;

  localparam int unsigned DIM_LIMIT     = 256;
  localparam int unsigned DEFAULT_DIM   = 32;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          RANDOM_PIXELS = 400;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          DRAIN_CYCLES  = 20;
  localparam logic [PIX_W-1:0] BLACK = '0;
  // Pattern bits from 6 down to 0: top, mid, bottom, left-top, left-bottom,
  // right-top, right-bottom.
  localparam logic [6:0] DIGIT_SEGS [10] = '{
    7'b1011111, 7'b0000011, 7'b1110110, 7'b1110011, 7'b0101111,
    7'b1111001, 7'b1111101, 7'b1000011, 7'b1111111, 7'b1111011
  };
  // For each pattern bit, a grid cell that lights that segment and no other.
  localparam int SEG_CELL [7] = '{11, 5, 9, 3, 13, 7, 1};

  logic clk = 1'b0;
  logic rst_n;

  gsdc_stream_if #(.T(in_item_t))  in_ch ();
  gsdc_stream_if #(.T(out_item_t)) out_ch ();
  gsdc_stream_if #(.T(cfg_item_t)) cfg_ch ();

  grid_segment_digit_classifier dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  in_item_t  pixel_queue [$];
  out_item_t digit_queue [$];

  bit idle_on;
  int send_gap;
  int stall_left;

  logic [DIM_W-1:0] width_reg, height_reg;
  logic [DIM_W-1:0] col_pos, row_pos;
  logic [DIM_W-1:0] box_min_x, box_max_x, box_min_y, box_max_y;
  logic [CNT_W-1:0] cell_cnt [NUM_CELLS];

  int error_count = 0;
  int results_checked = 0;
  int pixels_accepted = 0;
  int reg_writes = 0;
  int unrecognized_seen = 0;
  int stim_pixels = 0;
  int quiet_cycles = 0;
  logic [9:0] digits_seen = '0;

  always #1 clk = ~clk;

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  function automatic void start_frame(input int unsigned w, input int unsigned h);
    foreach (cell_cnt[i]) cell_cnt[i] = '0;
    col_pos = '0;
    row_pos = '0;
    box_min_x = DIM_W'(w);
    box_max_x = '0;
    box_min_y = DIM_W'(h);
    box_max_y = '0;
  endfunction

  function automatic bit seg_lit(input longint unsigned sum, input longint unsigned cells,
                                 input longint unsigned t);
    return 4 * sum > cells * t;
  endfunction

  function automatic out_item_t classify_frame(input int unsigned w, input int unsigned h);
    longint unsigned t, dx, dy;
    logic [6:0] seg;
    t = 64'(h / 5) * 64'(w / 3);
    seg[6] = seg_lit(64'(cell_cnt[0]) + 64'(cell_cnt[1]) + 64'(cell_cnt[2]), 3, t);
    seg[5] = seg_lit(64'(cell_cnt[6]) + 64'(cell_cnt[7]) + 64'(cell_cnt[8]), 3, t);
    seg[4] = seg_lit(64'(cell_cnt[12]) + 64'(cell_cnt[13]) + 64'(cell_cnt[14]), 3, t);
    seg[3] = seg_lit(64'(cell_cnt[0]) + 64'(cell_cnt[3]), 2, t);
    seg[2] = seg_lit(64'(cell_cnt[9]) + 64'(cell_cnt[12]), 2, t);
    seg[1] = seg_lit(64'(cell_cnt[2]) + 64'(cell_cnt[5]), 2, t);
    seg[0] = seg_lit(64'(cell_cnt[11]) + 64'(cell_cnt[14]), 2, t);
    for (int d = 0; d < 10; d++) begin
      if (seg == DIGIT_SEGS[d]) return '{digit: DIGIT_W'(d), recognized: 1'b1};
    end
    if (box_max_x <= box_min_x || box_max_y <= box_min_y) begin
      return '{digit: '0, recognized: 1'b0};
    end
    dx = 64'(box_max_x - box_min_x);
    dy = 64'(box_max_y - box_min_y);
    if (5 * dx > 4 * dy && 5 * dx < 6 * dy) return '{digit: DIGIT_W'(0), recognized: 1'b1};
    if (5 * dx < 3 * dy) return '{digit: DIGIT_W'(1), recognized: 1'b1};
    if (10 * dx > 7 * dy && 10 * dx < 13 * dy) begin
      return '{digit: seg[5] ? DIGIT_W'(8) : DIGIT_W'(0), recognized: 1'b1};
    end
    return '{digit: DIGIT_W'(8), recognized: 1'b1};
  endfunction

  task automatic predict_pixel(input in_item_t px);
    int unsigned w, h, gw, gh, x, y, k;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    if (px.start_of_frame) start_frame(w, h);
    if (row_pos >= h) return;
    x = col_pos;
    y = row_pos;
    if (px.pixel_value == BLACK) begin
      gh = h / 5;
      gw = w / 3;
      if (gh != 0 && gw != 0) begin
        if (y / gh < 5 && x / gw < 3) begin
          k = (y / gh) * 3 + x / gw;
          if (cell_cnt[k] != CNT_MAX) cell_cnt[k] = cell_cnt[k] + 1'b1;
        end
      end
      if (x < box_min_x) box_min_x = DIM_W'(x);
      if (x > box_max_x) box_max_x = DIM_W'(x);
      if (y < box_min_y) box_min_y = DIM_W'(y);
      if (y > box_max_y) box_max_y = DIM_W'(y);
    end
    if (x + 1 >= w) begin
      col_pos = '0;
      row_pos = DIM_W'(y + 1);
    end else begin
      col_pos = DIM_W'(x + 1);
    end
    if (row_pos >= h) digit_queue.push_back(classify_frame(w, h));
  endtask

  // Pixel driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        in_ch.data <= pixel_queue.pop_front();
        in_ch.valid <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 17);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor, predictor and watchdog.
  always @(posedge clk) begin : monitor
    out_item_t want;
    bit progress;
    if (!rst_n) begin
      width_reg = DIM_W'(DEFAULT_DIM);
      height_reg = DIM_W'(DEFAULT_DIM);
      start_frame(DEFAULT_DIM, DEFAULT_DIM);
      quiet_cycles = 0;
    end else begin
      progress = 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        progress = 1'b1;
        if (digit_queue.size() == 0) begin
          $display("%0t: unexpected result, digit %0d recognized %0b", $time,
                   out_ch.data.digit, out_ch.data.recognized);
          error_count++;
        end else begin
          want = digit_queue.pop_front();
          results_checked++;
          if (want.recognized) digits_seen[want.digit] = 1'b1;
          else unrecognized_seen++;
          if (out_ch.data.digit !== want.digit) begin
            $display("%0t: digit mismatch, expected %0d, actual %0d", $time,
                     want.digit, out_ch.data.digit);
            error_count++;
          end
          if (out_ch.data.recognized !== want.recognized) begin
            $display("%0t: recognized mismatch, expected %0b, actual %0b", $time,
                     want.recognized, out_ch.data.recognized);
            error_count++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        progress = 1'b1;
        reg_writes++;
        if (cfg_ch.data.index == REG_IMAGE_WIDTH) width_reg = cfg_ch.data.value;
        else height_reg = cfg_ch.data.value;
      end
      if (in_ch.valid && in_ch.ready) begin
        progress = 1'b1;
        pixels_accepted++;
        predict_pixel(in_ch.data);
      end
      if (progress) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                   QUIET_LIMIT, digit_queue.size());
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  function automatic void push_pixel(input logic [PIX_W-1:0] v, input bit sof);
    in_item_t px;
    px.pixel_value = v;
    px.start_of_frame = sof;
    pixel_queue.push_back(px);
  endfunction

  function automatic logic [PIX_W-1:0] white_level();
    return PIX_W'($urandom_range(1, 255));
  endfunction

  function automatic logic [NUM_CELLS-1:0] digit_mask(input int unsigned d);
    logic [NUM_CELLS-1:0] m;
    m = '0;
    for (int s = 0; s < 7; s++) begin
      if (DIGIT_SEGS[d][s]) m[SEG_CELL[s]] = 1'b1;
    end
    return m;
  endfunction

  // Queues up to count pixels of a w x h frame. Black pixels come from the
  // cell mask, or from a random rectangle, and noise_pm flips pixels.
  task automatic queue_frame(input int unsigned w, input int unsigned h,
                             input logic [NUM_CELLS-1:0] mask, input bit rect,
                             input int unsigned noise_pm, input int unsigned count);
    int unsigned gw, gh, x0, x1, y0, y1, n;
    bit black;
    gw = w / 3;
    gh = h / 5;
    x0 = $urandom_range(0, w - 1);
    x1 = $urandom_range(x0, w - 1);
    y0 = $urandom_range(0, h - 1);
    y1 = $urandom_range(y0, h - 1);
    n = 0;
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        if (n < count) begin
          if (rect) black = x >= x0 && x <= x1 && y >= y0 && y <= y1;
          else if (gw != 0 && gh != 0 && y / gh < 5 && x / gw < 3)
            black = mask[(y / gh) * 3 + x / gw];
          else black = 1'b0;
          if ($urandom_range(0, 999) < noise_pm) black = !black;
          push_pixel(black ? BLACK : white_level(), n == 0);
          n++;
        end
      end
    end
    stim_pixels += n;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || in_ch.valid || digit_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [DIM_W-1:0] v);
    @(posedge clk);
    cfg_ch.data.index <= idx;
    cfg_ch.data.value <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  initial begin : stimulus
    int unsigned w, h, base;
    bit sweep_done;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    idle_on = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // A zero width acts as one. The first pixel has no start mark.
    write_size(DIM_W'(0), DIM_W'(1));
    push_pixel(BLACK, 1'b0);
    push_pixel(8'hFF, 1'b0);
    push_pixel(BLACK, 1'b0);
    push_pixel(8'hFF, 1'b1);
    push_pixel(8'h80, 1'b1);
    push_pixel(BLACK, 1'b1);
    push_pixel(8'h7F, 1'b1);
    push_pixel(8'h01, 1'b1);

    // The frame is cut short when the height shrinks below the current row.
    write_size(DIM_W'(2), DIM_W'(2));
    push_pixel(BLACK, 1'b1);
    push_pixel(8'hAA, 1'b0);
    push_pixel(BLACK, 1'b0);
    write_size(DIM_W'(2), DIM_W'(1));
    push_pixel(BLACK, 1'b0);

    // The column is past the new width and wraps on the next pixel.
    write_size(DIM_W'(3), DIM_W'(2));
    push_pixel(BLACK, 1'b1);
    push_pixel(8'h55, 1'b0);
    write_size(DIM_W'(1), DIM_W'(2));
    push_pixel(BLACK, 1'b0);
    push_pixel(BLACK, 1'b0);

    // Register values above the maximum act as the maximum.
    write_size(DIM_W'(9'h1FF), DIM_W'(0));
    queue_frame(DIM_LIMIT, 1, '0, 1'b0, 200, DIM_LIMIT);
    write_size(DIM_W'(1), DIM_W'(300));
    queue_frame(1, DIM_LIMIT, '0, 1'b1, 5, DIM_LIMIT);

    base = stim_pixels;
    sweep_done = 1'b0;
    while (stim_pixels < base + RANDOM_PIXELS) begin
      if (stim_pixels + 150 > base + RANDOM_PIXELS) idle_on = 1'b0;
      else idle_on = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(1, 2);
          h = $urandom_range(1, 8);
        end
        1: begin
          w = $urandom_range(3, 8);
          h = $urandom_range(1, 4);
        end
        2: begin
          w = $urandom_range(9, 16);
          h = $urandom_range(10, 20);
        end
        default: begin
          w = $urandom_range(3, 7);
          h = $urandom_range(5, 11);
        end
      endcase
      if (!sweep_done) begin
        w = 3;
        h = 5;
      end
      write_size(DIM_W'(w), DIM_W'(h));
      if (!sweep_done) begin
        for (int d = 0; d < 10; d++) queue_frame(w, h, digit_mask(d), 1'b0, 0, w * h);
        sweep_done = 1'b1;
      end
      repeat ($urandom_range(2, 6)) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7:
            queue_frame(w, h, digit_mask($urandom_range(0, 9)), 1'b0,
                        $urandom_range(0, 30), w * h);
          8, 9, 10, 11:
            queue_frame(w, h, NUM_CELLS'($urandom), 1'b0, $urandom_range(0, 100), w * h);
          12, 13, 14:
            queue_frame(w, h, '0, 1'b1, $urandom_range(0, 20), w * h);
          15:
            queue_frame(w, h, '0, 1'b0, 0, w * h);
          16:
            queue_frame(w, h, '0, 1'b0, 1000, w * h);
          17:
            queue_frame(w, h, NUM_CELLS'($urandom), 1'b0, 50, $urandom_range(1, w * h));
          18: begin
            queue_frame(w, h, digit_mask($urandom_range(0, 9)), 1'b0, 10, w * h);
            repeat ($urandom_range(1, 5)) push_pixel(PIX_W'($urandom), 1'b0);
          end
          default: begin
            wait_idle();
            queue_frame(w, h, digit_mask($urandom_range(0, 9)), 1'b0, 0, w * h);
          end
        endcase
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d frame results from %0d accepted pixels and %0d register writes.",
             results_checked, pixels_accepted, reg_writes);
    $display("Recognized digits seen (bit per digit): %b; unrecognized frames: %0d.",
             digits_seen, unrecognized_seen);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
